@@ rtl/wfg_pkg.sv @@
// Shared types and constants of the window fold gather address generator.
// Depends on nothing; every other file of the block imports it.
package wfg_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 31;
    localparam int SIZE_W      = 7;
    localparam int STEP_W      = 16;
    localparam int FOLD_W      = 16;
    localparam int STRIDE_W    = 31;
    localparam int BASE_W      = 31;

    localparam logic [SIZE_W-1:0] MAX_WINDOW = 7'd64;

    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_SIZE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_STEP = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FOLD_COUNT  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FOLD_STRIDE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ELEM_STRIDE = 3'd4;

    // Effective configuration: window size saturated, zero step read as one.
    typedef struct packed {
        logic [SIZE_W-1:0]   size;
        logic [STEP_W-1:0]   step;
        logic [FOLD_W-1:0]   fold_count;
        logic [STRIDE_W-1:0] fold_stride;
        logic [STRIDE_W-1:0] elem_stride;
    } wfg_cfg_t;

    // One classified item handed from the front to the back.
    typedef struct packed {
        logic                empty;
        logic [FOLD_W-1:0]   first;
        logic [FOLD_W-1:0]   final_f;
        logic [SIZE_W-1:0]   win_ofs;
        logic [BASE_W-1:0]   base;
    } wfg_entry_t;

endpackage

@@ rtl/wfg_front.sv @@
// Front of the fold gather generator: accepts an item and finds its window range.
// Depends on wfg_pkg; two restoring dividers run in lockstep, one bit a cycle.
module wfg_front import wfg_pkg::*; #(
    parameter int PW = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  wfg_cfg_t      cfg,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [PW-1:0] position,
    input  logic [BASE_W-1:0] base_offset,
    output logic          push_valid,
    input  logic          push_ready,
    output wfg_entry_t    push_entry
);

    localparam int CW    = (PW > FOLD_W) ? PW : FOLD_W;
    localparam int CNT_W = $clog2(PW);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PW-1:0]     dvd1_reg, dvd1_next, dvd2_reg, dvd2_next;
    logic [STEP_W-1:0] rem1_reg, rem1_next, rem2_reg, rem2_next;
    logic [PW-1:0]     pos_reg;
    logic [BASE_W-1:0] base_reg;
    logic              ge_reg;

    logic [STEP_W:0]   trial1, trial2, sub1, sub2;
    logic              take1, take2;
    logic              accept;
    logic              pos_ge;
    logic [CW-1:0]     quot, fcm1, final_c;
    logic [CW:0]       first_c;
    logic [STEP_W:0]   within_w;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign pos_ge   = (CW'(position) >= CW'(cfg.size));

    // One quotient bit per cycle for pos/step and (pos-size)/step.
    always_comb
    begin
        trial1    = {rem1_reg, dvd1_reg[PW-1]};
        trial2    = {rem2_reg, dvd2_reg[PW-1]};
        sub1      = trial1 - {1'b0, cfg.step};
        sub2      = trial2 - {1'b0, cfg.step};
        take1     = (trial1 >= {1'b0, cfg.step});
        take2     = (trial2 >= {1'b0, cfg.step});
        rem1_next = take1 ? sub1[STEP_W-1:0] : trial1[STEP_W-1:0];
        rem2_next = take2 ? sub2[STEP_W-1:0] : trial2[STEP_W-1:0];
        dvd1_next = {dvd1_reg[PW-2:0], take1};
        dvd2_next = {dvd2_reg[PW-2:0], take2};
    end

    // Classify the item once both quotients are in.
    always_comb
    begin
        quot     = CW'(dvd1_reg);
        fcm1     = CW'(cfg.fold_count - 16'd1);
        final_c  = (quot > fcm1) ? fcm1 : quot;
        first_c  = ge_reg ? ((CW+1)'(dvd2_reg) + (CW+1)'(1)) : '0;
        within_w = {10'd0, cfg.size} + {1'b0, rem2_reg} - {1'b0, cfg.step};
        push_entry.empty   = (cfg.size == '0) || (cfg.fold_count == '0) ||
                             (first_c > {1'b0, final_c});
        push_entry.first   = first_c[FOLD_W-1:0];
        push_entry.final_f = final_c[FOLD_W-1:0];
        push_entry.win_ofs = ge_reg ? within_w[SIZE_W-1:0] : pos_reg[SIZE_W-1:0];
        push_entry.base    = base_reg;
    end

    assign push_valid = (state_reg == ST_PUSH);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (accept)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(PW - 1))
                    state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (push_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pos_reg  <= position;
            base_reg <= base_offset;
            ge_reg   <= pos_ge;
            dvd1_reg <= position;
            dvd2_reg <= pos_ge ? (position - PW'(cfg.size)) : '0;
            rem1_reg <= '0;
            rem2_reg <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            dvd1_reg <= dvd1_next;
            dvd2_reg <= dvd2_next;
            rem1_reg <= rem1_next;
            rem2_reg <= rem2_next;
        end
    end

endmodule

@@ rtl/wfg_queue.sv @@
// Two-entry queue of classified items between front and back.
// Depends on wfg_pkg for the entry type.
module wfg_queue import wfg_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  wfg_entry_t push_entry,
    output logic       pop_valid,
    input  logic       pop_ready,
    output wfg_entry_t pop_entry
);

    wfg_entry_t mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

@@ rtl/wfg_back.sv @@
// Back of the fold gather generator: walks the window range, one beat a cycle unless out_stall holds it.
// Depends on wfg_pkg; offsets advance by a per-item delta after one multiply stage.
module wfg_back import wfg_pkg::*; #(
    parameter int OW = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  wfg_cfg_t      cfg,
    input  logic          pop_valid,
    output logic          pop_ready,
    input  wfg_entry_t    pop_entry,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [OW-1:0] source_offset,
    output logic [FOLD_W-1:0] window_index,
    output logic          contributes,
    output logic          last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_SUM  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]        state_reg, state_next;
    wfg_entry_t        ent_reg;
    logic [OW-1:0]     p1_reg, p2_reg, p3_reg;
    logic [OW-1:0]     off_reg, delta_reg;
    logic [FOLD_W-1:0] f_reg;
    logic              out_valid_reg;
    logic [OW-1:0]     source_offset_reg;
    logic [FOLD_W-1:0] window_index_reg;
    logic              contributes_reg, last_reg;

    logic [46:0]       p1_full, p3_full;
    logic [37:0]       p2_full;
    logic              load, is_last;

    assign pop_ready = (state_reg == ST_IDLE);
    assign load      = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);
    assign is_last   = ent_reg.empty || (f_reg == ent_reg.final_f);

    assign p1_full = 47'(ent_reg.first) * 47'(cfg.fold_stride);
    assign p2_full = 38'(ent_reg.win_ofs) * 38'(cfg.elem_stride);
    assign p3_full = 47'(cfg.step) * 47'(cfg.elem_stride);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (load && is_last)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_valid && pop_ready)
            ent_reg <= pop_entry;
        if (state_reg == ST_MUL)
        begin
            p1_reg <= p1_full[OW-1:0];
            p2_reg <= p2_full[OW-1:0];
            p3_reg <= p3_full[OW-1:0];
        end
        if (state_reg == ST_SUM)
        begin
            off_reg   <= OW'(ent_reg.base) + p1_reg + p2_reg;
            delta_reg <= OW'(cfg.fold_stride) - p3_reg;
            f_reg     <= ent_reg.first;
        end
        if (load)
        begin
            source_offset_reg <= ent_reg.empty ? '0 : off_reg;
            window_index_reg  <= ent_reg.empty ? '0 : f_reg;
            contributes_reg   <= !ent_reg.empty;
            last_reg          <= is_last;
            off_reg           <= off_reg + delta_reg;
            f_reg             <= f_reg + 16'd1;
        end
    end

    assign out_valid     = out_valid_reg;
    assign source_offset = source_offset_reg;
    assign window_index  = window_index_reg;
    assign contributes   = contributes_reg;
    assign last          = last_reg;

endmodule

@@ rtl/window_fold_gather_address_generator.sv @@
// Window fold gather address generator: for each output position, emit the
// source offsets of every sliding window that covers it, in ascending window
// order. The front divides the position (and the position less the window
// size) by the window step, one quotient bit per cycle. A two-entry queue
// separates it from the back, which runs its multiply and sum stages and then
// emits the result beats in turn, held by out_stall. Front and back overlap,
// with at most 64 results per item. A position that no window covers yields
// one beat with contributes low, offset and index zero.
// Configuration registers take writes in any cycle (cfg_ready is always high)
// but are meant to change only while the block is idle.
module window_fold_gather_address_generator import wfg_pkg::*; #(
    parameter int POSITION_WIDTH = 16,
    parameter int OFFSET_WIDTH   = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [POSITION_WIDTH-1:0] position,
    input  logic [BASE_W-1:0]         base_offset,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [OFFSET_WIDTH-1:0]   source_offset,
    output logic [FOLD_W-1:0]         window_index,
    output logic                      contributes,
    output logic                      last
);

    // Configuration registers, reset to a single one-element window.
    logic [SIZE_W-1:0]   window_size_reg;
    logic [STEP_W-1:0]   window_step_reg;
    logic [FOLD_W-1:0]   fold_count_reg;
    logic [STRIDE_W-1:0] fold_stride_reg;
    logic [STRIDE_W-1:0] elem_stride_reg;
    wfg_cfg_t            cfg;

    logic       push_valid, push_ready, pop_valid, pop_ready;
    wfg_entry_t push_entry, pop_entry;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= 7'd1;
            window_step_reg <= 16'd1;
            fold_count_reg  <= 16'd1;
            fold_stride_reg <= '0;
            elem_stride_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_WINDOW_SIZE: window_size_reg <= cfg_data[SIZE_W-1:0];
                REG_WINDOW_STEP: window_step_reg <= cfg_data[STEP_W-1:0];
                REG_FOLD_COUNT:  fold_count_reg  <= cfg_data[FOLD_W-1:0];
                REG_FOLD_STRIDE: fold_stride_reg <= cfg_data;
                REG_ELEM_STRIDE: elem_stride_reg <= cfg_data;
                default:
                begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    // Saturate the window size at 64 and read a zero step as one.
    always_comb
    begin
        cfg.size        = (window_size_reg > MAX_WINDOW) ? MAX_WINDOW : window_size_reg;
        cfg.step        = (window_step_reg == '0) ? 16'd1 : window_step_reg;
        cfg.fold_count  = fold_count_reg;
        cfg.fold_stride = fold_stride_reg;
        cfg.elem_stride = elem_stride_reg;
    end

    wfg_front #(
        .PW (POSITION_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .position    (position),
        .base_offset (base_offset),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_entry  (push_entry)
    );

    wfg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    wfg_back #(
        .OW (OFFSET_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_entry     (pop_entry),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .source_offset (source_offset),
        .window_index  (window_index),
        .contributes   (contributes),
        .last          (last)
    );

`ifndef SYNTH
    // An uncovered position ends its item at once.
    a_uncovered_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !contributes |-> last)
        else $error("non-contributing beat without last");

    // An uncovered beat carries zero offset and window index.
    a_uncovered_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !contributes |-> (source_offset == '0) && (window_index == '0))
        else $error("non-contributing beat with nonzero fields");

    // The front is busy dividing right after it takes an item.
    a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("front accepted back-to-back items");
`endif

endmodule
